FILE: src/mhld_pkg.sv
// ----------------------------------------------------------------------------
// mhld_pkg
// Shared types and constants for the magic header / length deframer.
// ----------------------------------------------------------------------------
package mhld_pkg;

  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 16;
  localparam int MAGIC_DEPTH = 16;
  localparam int MAGIC_IDX_W = 4;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;
  localparam int QUEUE_CW    = 3;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LEN_HI  = 2'd1,
    PH_LEN_LO  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  typedef struct packed {
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;
    logic              frame_empty;
  } res_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  localparam logic [BYTE_W-1:0] MAGIC_TABLE [MAGIC_DEPTH] = '{
    8'hFF, 8'h00, 8'hEE, 8'h11, 8'hDD, 8'h22, 8'hCC, 8'h33,
    8'hBB, 8'h44, 8'hAA, 8'h55, 8'h99, 8'h66, 8'h00, 8'h00
  };

endpackage

FILE: src/mhld_front.sv
// ----------------------------------------------------------------------------
// mhld_front
// Frame parser: walks header, length and payload, pushes result items.
// ----------------------------------------------------------------------------
module mhld_front #(
  parameter int HEADER_BYTES = 14
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          byte_in,
  output logic                push,
  output mhld_pkg::res_t      push_res
);
  import mhld_pkg::*;

  localparam int HDR_CNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam logic [HDR_CNT_W-1:0] HDR_LAST = HDR_CNT_W'(HEADER_BYTES - 1);

  phase_t               phase, phase_next;
  logic [HDR_CNT_W-1:0] hdr_pos, hdr_pos_next;
  logic [LEN_W-1:0]     pay_pos, pay_pos_next;
  logic                 header_matched, header_matched_next;
  logic [BYTE_W-1:0]    length_high, length_high_next;
  logic [LEN_W-1:0]     payload_length, payload_length_next;

  logic [LEN_W-1:0]     len_word;
  logic                 pay_last;
  logic                 magic_hit;

  assign len_word  = {length_high, byte_in};
  assign pay_last  = ({1'b0, pay_pos} + (LEN_W+1)'(1)) >= {1'b0, payload_length};
  assign magic_hit = byte_in == MAGIC_TABLE[MAGIC_IDX_W'(hdr_pos)];

  always_comb begin
    phase_next          = phase;
    hdr_pos_next        = hdr_pos;
    pay_pos_next        = pay_pos;
    header_matched_next = header_matched;
    length_high_next    = length_high;
    payload_length_next = payload_length;
    if (accept) begin
      case (phase)
        PH_HEADER: begin
          if (!magic_hit) header_matched_next = 1'b0;
          if (hdr_pos == HDR_LAST) begin
            hdr_pos_next = '0;
            phase_next   = PH_LEN_HI;
          end else begin
            hdr_pos_next = hdr_pos + HDR_CNT_W'(1);
          end
        end
        PH_LEN_HI: begin
          length_high_next = byte_in;
          phase_next       = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          payload_length_next = len_word;
          pay_pos_next        = '0;
          if (len_word == '0) begin
            phase_next          = PH_HEADER;
            hdr_pos_next        = '0;
            header_matched_next = 1'b1;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (pay_last) begin
            phase_next          = PH_HEADER;
            hdr_pos_next        = '0;
            pay_pos_next        = '0;
            header_matched_next = 1'b1;
          end else begin
            pay_pos_next = pay_pos + LEN_W'(1);
          end
        end
        default: phase_next = PH_HEADER;
      endcase
    end
  end

  always_comb begin
    push                  = 1'b0;
    push_res.payload_byte = byte_in;
    push_res.frame_last   = pay_last;
    push_res.frame_empty  = 1'b0;
    case (phase)
      PH_LEN_LO: begin
        push                  = accept && header_matched && (len_word == '0);
        push_res.payload_byte = '0;
        push_res.frame_last   = 1'b1;
        push_res.frame_empty  = 1'b1;
      end
      PH_PAYLOAD: push = accept && header_matched;
      default:    push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      hdr_pos        <= '0;
      pay_pos        <= '0;
      header_matched <= 1'b1;
      length_high    <= '0;
      payload_length <= '0;
    end else begin
      phase          <= phase_next;
      hdr_pos        <= hdr_pos_next;
      pay_pos        <= pay_pos_next;
      header_matched <= header_matched_next;
      length_high    <= length_high_next;
      payload_length <= payload_length_next;
    end
  end

endmodule

FILE: src/mhld_queue.sv
// ----------------------------------------------------------------------------
// mhld_queue
// Short result queue between parser and output stage.
// ----------------------------------------------------------------------------
module mhld_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  mhld_pkg::res_t         push_res,
  input  logic                   pop,
  output mhld_pkg::res_t         head_res,
  output mhld_pkg::queue_stat_t  stat
);
  import mhld_pkg::*;

  res_t                slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign stat.full  = count == QUEUE_CW'(QUEUE_DEPTH);
  assign stat.empty = count == '0;
  assign head_res   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + QUEUE_CW'(1);
        2'b01:   count <= count - QUEUE_CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/mhld_back.sv
// ----------------------------------------------------------------------------
// mhld_back
// Output register: drains the queue onto the master stream.
// ----------------------------------------------------------------------------
module mhld_back (
  input  logic                   clk,
  input  logic                   rst,
  input  mhld_pkg::queue_stat_t  stat,
  input  mhld_pkg::res_t         head_res,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mhld_pkg::res_t         out_res
);
  import mhld_pkg::*;

  assign pop = !stat.empty && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) out_res <= head_res;
  end

endmodule

FILE: src/magic_header_length_deframer_core.sv
// ----------------------------------------------------------------------------
// magic_header_length_deframer_core
// Magic header / 16-bit length deframer, one byte per clock while the result queue is not full.
// ----------------------------------------------------------------------------
//  channel   dir  payload
//  s_axis    in   tdata[7:0] = byte_in
//  m_axis    out  tdata[7:0] = payload_byte, tlast = frame_last,
//                 tuser = frame_empty
//
//  One byte per clock sustained; a result passes through a queue slot and then the output register.
//  Input stalls only when the four-entry result queue is full.
//  rst is synchronous; parser restarts at the header, queue and output empty.
//  m_axis stalls back up through the queue independently of the parser.
// ----------------------------------------------------------------------------
module magic_header_length_deframer_core #(
  parameter int HEADER_BYTES = 14
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] payload_byte
  output logic       m_axis_tlast,
  output logic       m_axis_tuser    // [0] frame_empty
);
  import mhld_pkg::*;

  logic        accept;
  logic        push;
  logic        pop;
  res_t        push_res;
  res_t        head_res;
  res_t        out_res;
  queue_stat_t stat;

  assign s_axis_tready = !stat.full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  mhld_front #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .byte_in  (s_axis_tdata),
    .push     (push),
    .push_res (push_res)
  );

  mhld_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_res (push_res),
    .pop      (pop),
    .head_res (head_res),
    .stat     (stat)
  );

  mhld_back u_back (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .head_res  (head_res),
    .pop       (pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_res   (out_res)
  );

  assign m_axis_tdata = out_res.payload_byte;
  assign m_axis_tlast = out_res.frame_last;
  assign m_axis_tuser = out_res.frame_empty;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench for magic_header_length_deframer_core. Frames are built into a
// byte queue and driven in several flow-control phases. Every accepted byte
// runs through a local deframer model, and every result is checked against
// the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
  import mhld_pkg::*;

  localparam int HDR_LEN         = 14;
  localparam int CYCLE_LIMIT     = 600000;
  localparam int BYTES_PER_PHASE = 300;
  localparam int DRAIN_CYCLES    = 20;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic       m_axis_tlast;
  logic       m_axis_tuser;

  logic [7:0] byte_queue[$];
  res_t       pending_results[$];
  res_t       head_result;
  int         send_idle_pct  = 0;
  int         recv_stall_pct = 0;
  bit         byte_taken     = 1'b0;
  int         error_count    = 0;
  int         cycle_count    = 0;

  // deframer model state
  phase_t      rx_phase  = PH_HEADER;
  logic [15:0] rx_pos    = '0;
  logic        hdr_ok    = 1'b1;
  logic [7:0]  len_msb   = '0;
  logic [15:0] frame_len = '0;

  magic_header_length_deframer_core #(
    .HEADER_BYTES(HDR_LEN)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic restart_frame();
    rx_phase = PH_HEADER;
    rx_pos   = '0;
    hdr_ok   = 1'b1;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    logic last;
    res_t r;
    case (rx_phase)
      PH_HEADER: begin
        if (b != MAGIC_TABLE[rx_pos[3:0]]) hdr_ok = 1'b0;
        rx_pos = rx_pos + 16'd1;
        if (rx_pos >= HDR_LEN) begin
          rx_pos   = '0;
          rx_phase = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        len_msb  = b;
        rx_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        frame_len = {len_msb, b};
        rx_pos    = '0;
        if (frame_len == 16'd0) begin
          if (hdr_ok) begin
            r.payload_byte = 8'h00;
            r.frame_last   = 1'b1;
            r.frame_empty  = 1'b1;
            pending_results.push_back(r);
          end
          restart_frame();
        end else begin
          rx_phase = PH_PAYLOAD;
        end
      end
      default: begin
        last = (32'(rx_pos) + 32'd1) >= 32'(frame_len);
        if (hdr_ok) begin
          r.payload_byte = b;
          r.frame_last   = last;
          r.frame_empty  = 1'b0;
          pending_results.push_back(r);
        end
        if (last) restart_frame();
        else rx_pos = rx_pos + 16'd1;
      end
    endcase
  endtask

  // corrupt_at < 0: no corrupted header byte; fill < 0: random payload
  task automatic queue_frame(input int corrupt_at, input bit scramble,
                             input int unsigned len, input int fill);
    logic [7:0]  hb;
    logic [15:0] len16;
    len16 = len[15:0];
    for (int i = 0; i < HDR_LEN; i++) begin
      hb = MAGIC_TABLE[i];
      if (scramble) hb = 8'($urandom_range(255));
      else if (i == corrupt_at) hb = hb ^ 8'($urandom_range(1, 255));
      byte_queue.push_back(hb);
    end
    byte_queue.push_back(len16[15:8]);
    byte_queue.push_back(len16[7:0]);
    for (int unsigned i = 0; i < len; i++)
      byte_queue.push_back(fill < 0 ? 8'($urandom_range(255)) : 8'(fill));
  endtask

  task automatic random_traffic(input int n_bytes);
    int          added;
    int          kind;
    int unsigned len;
    added = 0;
    while (added < n_bytes) begin
      kind = $urandom_range(99);
      len  = ($urandom_range(9) == 0) ? $urandom_range(300) : $urandom_range(24);
      if (kind < 70) queue_frame(-1, 1'b0, len, -1);
      else if (kind < 85) queue_frame($urandom_range(HDR_LEN - 1), 1'b0, len, -1);
      else queue_frame(-1, 1'b1, len, -1);
      added += HDR_LEN + 2 + len;
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || s_axis_tvalid) @(posedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // sender and receiver
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || byte_taken) begin
      if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= byte_queue.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // accepted bytes feed the model; results are checked in order
  always @(posedge clk) begin
    byte_taken <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && s_axis_tvalid && s_axis_tready) deframe_byte(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: payload_byte %02h frame_last %0b frame_empty %0b",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (m_axis_tdata !== head_result.payload_byte) begin
          $error("payload_byte: expected %02h, got %02h",
                 head_result.payload_byte, m_axis_tdata);
          error_count++;
        end
        if (m_axis_tlast !== head_result.frame_last) begin
          $error("frame_last: expected %0b, got %0b", head_result.frame_last, m_axis_tlast);
          error_count++;
        end
        if (m_axis_tuser !== head_result.frame_empty) begin
          $error("frame_empty: expected %0b, got %0b",
                 head_result.frame_empty, m_axis_tuser);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int idle_mix[4];
    int stall_mix[4];
    idle_mix  = '{0, 73, 0, 23};
    stall_mix = '{0, 0, 73, 23};
    repeat (7) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed frames
    queue_frame(-1, 1'b0, 0, -1);
    queue_frame(-1, 1'b0, 1, 8'h00);
    queue_frame(-1, 1'b0, 2, 8'hFF);
    queue_frame(0, 1'b0, 3, -1);
    queue_frame(HDR_LEN - 1, 1'b0, 3, -1);
    queue_frame(-1, 1'b1, 0, -1);
    queue_frame(-1, 1'b0, 257, -1);
    queue_frame(-1, 1'b0, 1, -1);
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      @(posedge clk);
      send_idle_pct  = idle_mix[ph];
      recv_stall_pct = stall_mix[ph];
      random_traffic(BYTES_PER_PHASE);
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: magic_header_length_deframer_core.f
src/mhld_pkg.sv
src/mhld_front.sv
src/mhld_queue.sv
src/mhld_back.sv
src/magic_header_length_deframer_core.sv
sim/tb.sv
